// File: hdl/tkpt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tkpt_pkg
// Shared types of the top-k peak and trough finder: queue command codes and
// the back-end sequencer states.
// ----------------------------------------------------------------------------
package tkpt_pkg;

    // command codes carried through the front-to-back queue
    typedef enum logic [1:0] {
        OP_PEAK   = 2'd0,
        OP_TROUGH = 2'd1,
        OP_REPORT = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_RPT_READ,
        BK_RPT_LOAD
    } back_state_t;

endpackage
`default_nettype wire

// File: hdl/tkpt_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tkpt_front
// Input side: trims leading zeros, tracks rise/fall, turns each sample into
// keep-peak, keep-trough and report commands pushed one per cycle while the queue is not full.
// ----------------------------------------------------------------------------
module tkpt_front
    import tkpt_pkg::*;
#(
    parameter int FRAME_MAX = 128,
    localparam int IW = $clog2(FRAME_MAX),
    localparam int CMD_W = 2 + 16 + IW
)
(
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      in_valid,
    output logic                     in_stall,
    input  wire  signed [15:0]       sample,
    input  wire                      frame_end,
    output logic                     push,
    output logic [CMD_W-1:0]         push_data,
    input  wire                      fifo_full
);

    typedef struct packed {
        op_t                op;
        logic signed [15:0] value;
        logic [IW-1:0]      t;
    } cmd_t;

    typedef struct packed {
        logic rising;
        logic falling;
        logic peak;
        logic trough;
    } pair_t;

    function automatic pair_t compare_pair(input logic signed [15:0] a,
                                           input logic signed [15:0] b,
                                           input logic rising,
                                           input logic falling);
        pair_t r;
        logic  up;
        logic  down;
        up        = b > a;
        down      = b < a;
        r.rising  = rising | up;
        r.falling = falling | down;
        r.peak    = down & r.rising;
        if (r.peak)
        begin
            r.rising = 1'b0;
        end
        r.trough  = up & r.falling;
        if (r.trough)
        begin
            r.falling = 1'b0;
        end
        return r;
    endfunction

    logic [IW:0]        sample_index_reg, sample_index_next;
    logic               seen_reg, seen_next;
    logic [IW-1:0]      start_reg, start_next;
    logic signed [15:0] prev_reg, prev_next;
    logic [IW-1:0]      lastnz_reg, lastnz_next;
    logic               rising_reg, rising_next;
    logic               falling_reg, falling_next;
    logic               zpend_reg, zpend_next;
    cmd_t               pend_reg [3];
    cmd_t               pend_next [3];
    logic [1:0]         pend_cnt_reg, pend_cnt_next;

    logic               accept;
    logic [IW-1:0]      t;
    logic [IW-1:0]      t_m1;
    pair_t              p1;
    pair_t              p2;
    logic               k1_v, k2_v, rep_v;
    cmd_t               k1, k2, rep;
    cmd_t               lst [3];
    logic [1:0]         n;

    assign in_stall  = pend_cnt_reg != 2'd0;
    assign accept    = in_valid && !in_stall;
    assign push      = (pend_cnt_reg != 2'd0) && !fifo_full;
    assign push_data = pend_reg[0];
    assign t         = sample_index_reg[IW-1:0];
    assign t_m1      = t - IW'(1);

    always_comb
    begin
        sample_index_next = sample_index_reg;
        seen_next         = seen_reg;
        start_next        = start_reg;
        prev_next         = prev_reg;
        lastnz_next       = lastnz_reg;
        rising_next       = rising_reg;
        falling_next      = falling_reg;
        zpend_next        = zpend_reg;
        pend_next         = pend_reg;
        pend_cnt_next     = pend_cnt_reg;
        p1                = '0;
        p2                = '0;
        k1_v              = 1'b0;
        k2_v              = 1'b0;
        rep_v             = 1'b0;
        k1                = '0;
        k2                = '0;
        rep               = '0;
        lst               = pend_reg;
        n                 = 2'd0;

        if (accept)
        begin
            if (sample_index_reg < (IW+1)'(FRAME_MAX))
            begin
                sample_index_next = sample_index_reg + 1'b1;
                if (!seen_reg)
                begin
                    if (sample != 16'sd0)
                    begin
                        seen_next   = 1'b1;
                        start_next  = t;
                        prev_next   = sample;
                        lastnz_next = t;
                    end
                end
                else if (sample == 16'sd0)
                begin
                    zpend_next = 1'b1;
                end
                else
                begin
                    if (zpend_reg)
                    begin
                        // held comparison into the zero run, then out of it
                        p1 = compare_pair(prev_reg, 16'sd0, rising_reg, falling_reg);
                        p2 = compare_pair(16'sd0, sample, p1.rising, p1.falling);
                        k1_v         = p1.peak | p1.trough;
                        k1.op        = p1.peak ? OP_PEAK : OP_TROUGH;
                        k1.value     = prev_reg;
                        k1.t         = lastnz_reg;
                        k2_v         = p2.peak | p2.trough;
                        k2.op        = p2.peak ? OP_PEAK : OP_TROUGH;
                        k2.value     = 16'sd0;
                        k2.t         = t_m1;
                        rising_next  = p2.rising;
                        falling_next = p2.falling;
                        zpend_next   = 1'b0;
                    end
                    else
                    begin
                        p1 = compare_pair(prev_reg, sample, rising_reg, falling_reg);
                        k1_v         = p1.peak | p1.trough;
                        k1.op        = p1.peak ? OP_PEAK : OP_TROUGH;
                        k1.value     = prev_reg;
                        k1.t         = t_m1;
                        rising_next  = p1.rising;
                        falling_next = p1.falling;
                    end
                    prev_next   = sample;
                    lastnz_next = t;
                end
            end

            if (frame_end)
            begin
                rep_v             = 1'b1;
                rep.op            = OP_REPORT;
                rep.value         = 16'sd0;
                rep.t             = start_next;
                sample_index_next = '0;
                seen_next         = 1'b0;
                start_next        = '0;
                prev_next         = 16'sd0;
                lastnz_next       = '0;
                rising_next       = 1'b0;
                falling_next      = 1'b0;
                zpend_next        = 1'b0;
            end

            // pack the commands of this sample to the front of the list
            if (k1_v)
            begin
                lst[n] = k1;
                n      = n + 2'd1;
            end
            if (k2_v)
            begin
                lst[n] = k2;
                n      = n + 2'd1;
            end
            if (rep_v)
            begin
                lst[n] = rep;
                n      = n + 2'd1;
            end
            pend_next     = lst;
            pend_cnt_next = n;
        end
        else if (push)
        begin
            pend_next[0]  = pend_reg[1];
            pend_next[1]  = pend_reg[2];
            pend_cnt_next = pend_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_index_reg <= '0;
            seen_reg         <= 1'b0;
            start_reg        <= '0;
            prev_reg         <= 16'sd0;
            lastnz_reg       <= '0;
            rising_reg       <= 1'b0;
            falling_reg      <= 1'b0;
            zpend_reg        <= 1'b0;
            pend_cnt_reg     <= 2'd0;
        end
        else
        begin
            sample_index_reg <= sample_index_next;
            seen_reg         <= seen_next;
            start_reg        <= start_next;
            prev_reg         <= prev_next;
            lastnz_reg       <= lastnz_next;
            rising_reg       <= rising_next;
            falling_reg      <= falling_next;
            zpend_reg        <= zpend_next;
            pend_cnt_reg     <= pend_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
    end

    // the frame state is back at its start after the final sample
    a_frame_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        accept && frame_end |=> !seen_reg && (sample_index_reg == '0) && !zpend_reg)
        else $error("frame state not cleared after frame end");

endmodule
`default_nettype wire

// File: hdl/tkpt_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tkpt_fifo
// Four-entry command queue between the front end and the slot engine.
// ----------------------------------------------------------------------------
module tkpt_fifo
#(
    parameter int W = 8
)
(
    input  wire            clk,
    input  wire            rst_n,
    input  wire            push,
    input  wire  [W-1:0]   push_data,
    output logic           full,
    input  wire            pop,
    output logic [W-1:0]   head_data,
    output logic           head_valid
);

    localparam int DEPTH = 4;
    localparam int PW    = 2;

    logic [W-1:0]  mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW:0]   count_reg, count_next;

    assign full       = count_reg == (PW+1)'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("command queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("command queue underflow");

endmodule
`default_nettype wire

// File: hdl/tkpt_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tkpt_back
// Slot engine: scans the kept slots for the weakest one, replaces it with a
// stronger candidate, and streams out the slot times on a report.
// ----------------------------------------------------------------------------
module tkpt_back
    import tkpt_pkg::*;
#(
    parameter int SLOT_MAX = 8,
    parameter int FRAME_MAX = 128,
    localparam int IW = $clog2(FRAME_MAX),
    localparam int CMD_W = 2 + 16 + IW
)
(
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire  [3:0]               peak_slots,
    input  wire  [3:0]               trough_slots,
    input  wire                      head_valid,
    input  wire  [CMD_W-1:0]         head_data,
    output logic                     pop,
    output logic                     out_valid,
    input  wire                      out_stall,
    output logic                     kind,
    output logic [2:0]               slot,
    output logic signed [7:0]        time_res,
    output logic                     run_last
);

    localparam int SW    = (SLOT_MAX > 1) ? $clog2(SLOT_MAX) : 1;
    localparam int CW    = $clog2(SLOT_MAX + 1);
    localparam int DW    = (IW > 8) ? IW : 8;
    localparam int DEPTH = 2 ** (SW + 1);

    localparam logic signed [15:0] VAL_INIT_PEAK   = -16'sd5120;
    localparam logic signed [15:0] VAL_INIT_TROUGH = 16'sd5120;

    typedef struct packed {
        op_t                op;
        logic signed [15:0] value;
        logic [IW-1:0]      t;
    } cmd_t;

    typedef struct packed {
        logic signed [15:0] value;
        logic [IW-1:0]      t;
    } slot_t;

    function automatic logic [CW-1:0] active_count(input logic [3:0] c);
        if (c == 4'd0)
        begin
            return CW'(1);
        end
        else if (int'(c) > SLOT_MAX)
        begin
            return CW'(SLOT_MAX);
        end
        else
        begin
            return CW'(c);
        end
    endfunction

    back_state_t        state_reg, state_next;
    logic               kind_reg, kind_next;
    logic [SW-1:0]      idx_reg, idx_next;
    logic signed [15:0] cmd_val_reg, cmd_val_next;
    logic [IW-1:0]      cmd_t_reg, cmd_t_next;
    logic [IW-1:0]      start_reg, start_next;
    logic signed [15:0] best_val_reg, best_val_next;
    logic [SW-1:0]      best_pos_reg, best_pos_next;
    logic [DEPTH-1:0]   valid_reg, valid_next;

    slot_t              mem [DEPTH];
    slot_t              rd_data_reg;
    logic               rd_vld_reg;

    logic               out_valid_reg, out_valid_next;
    logic               out_kind_reg, out_kind_next;
    logic [2:0]         out_slot_reg, out_slot_next;
    logic signed [7:0]  out_time_reg, out_time_next;
    logic               out_last_reg, out_last_next;

    cmd_t               head;
    logic [CW-1:0]      n_cur;
    logic               is_last;
    logic signed [15:0] eff_val;
    logic [IW-1:0]      eff_t;
    logic               out_free;
    logic               out_load;
    logic               better;
    logic               stronger;
    logic signed [15:0] cur_best;
    logic [SW-1:0]      cur_pos;
    logic [SW:0]        rd_addr;
    logic [SW:0]        wr_addr;
    logic               wr_en;
    slot_t              wr_data;
    logic               clear_valid;

    assign head     = head_data;
    assign n_cur    = kind_reg ? active_count(trough_slots) : active_count(peak_slots);
    assign is_last  = CW'(idx_reg) == (n_cur - CW'(1));
    assign eff_val  = rd_vld_reg ? rd_data_reg.value
                                 : (kind_reg ? VAL_INIT_TROUGH : VAL_INIT_PEAK);
    assign eff_t    = rd_vld_reg ? rd_data_reg.t : '0;
    assign out_free = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign kind      = out_kind_reg;
    assign slot      = out_slot_reg;
    assign time_res  = out_time_reg;
    assign run_last  = out_last_reg;

    always_comb
    begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        idx_next      = idx_reg;
        cmd_val_next  = cmd_val_reg;
        cmd_t_next    = cmd_t_reg;
        start_next    = start_reg;
        best_val_next = best_val_reg;
        best_pos_next = best_pos_reg;
        out_kind_next = out_kind_reg;
        out_slot_next = out_slot_reg;
        out_time_next = out_time_reg;
        out_last_next = out_last_reg;
        rd_addr       = {kind_reg, idx_reg};
        wr_en         = 1'b0;
        wr_addr       = {kind_reg, best_pos_reg};
        wr_data.value = cmd_val_reg;
        wr_data.t     = cmd_t_reg;
        pop           = 1'b0;
        out_load      = 1'b0;
        clear_valid   = 1'b0;
        better        = 1'b0;
        stronger      = 1'b0;
        cur_best      = best_val_reg;
        cur_pos       = best_pos_reg;

        unique case (state_reg)
            BK_IDLE:
            begin
                rd_addr = {head.op == OP_TROUGH, SW'(0)};
                if (head_valid)
                begin
                    pop      = 1'b1;
                    idx_next = '0;
                    unique case (head.op) inside
                        OP_PEAK, OP_TROUGH:
                        begin
                            kind_next    = head.op == OP_TROUGH;
                            cmd_val_next = head.value;
                            cmd_t_next   = head.t;
                            state_next   = BK_SCAN;
                        end
                        OP_REPORT:
                        begin
                            kind_next  = 1'b0;
                            start_next = head.t;
                            state_next = BK_RPT_LOAD;
                        end
                        default:
                        begin
                            state_next = BK_IDLE;
                        end
                    endcase
                end
            end

            BK_SCAN:
            begin
                // first weakest slot: smallest peak or largest trough
                better = (idx_reg == '0) ||
                         (kind_reg ? (eff_val > best_val_reg) : (eff_val < best_val_reg));
                cur_best      = better ? eff_val : best_val_reg;
                cur_pos       = better ? idx_reg : best_pos_reg;
                best_val_next = cur_best;
                best_pos_next = cur_pos;
                if (is_last)
                begin
                    stronger = kind_reg ? (cmd_val_reg < cur_best) : (cmd_val_reg > cur_best);
                    if (stronger)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = {kind_reg, cur_pos};
                    end
                    state_next = BK_IDLE;
                end
                else
                begin
                    idx_next = SW'(idx_reg + 1'b1);
                    rd_addr  = {kind_reg, SW'(idx_reg + 1'b1)};
                end
            end

            BK_RPT_READ:
            begin
                state_next = BK_RPT_LOAD;
            end

            BK_RPT_LOAD:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_kind_next = kind_reg;
                    out_slot_next = 3'(idx_reg);
                    out_time_next = 8'(DW'(eff_t) - DW'(start_reg));
                    out_last_next = kind_reg && is_last;
                    if (is_last)
                    begin
                        if (!kind_reg)
                        begin
                            kind_next  = 1'b1;
                            idx_next   = '0;
                            state_next = BK_RPT_READ;
                        end
                        else
                        begin
                            clear_valid = 1'b1;
                            state_next  = BK_IDLE;
                        end
                    end
                    else
                    begin
                        idx_next   = SW'(idx_reg + 1'b1);
                        state_next = BK_RPT_READ;
                    end
                end
            end

            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        out_valid_next = out_load || (out_valid_reg && out_stall);

        valid_next = valid_reg;
        if (wr_en)
        begin
            valid_next[wr_addr] = 1'b1;
        end
        if (clear_valid)
        begin
            valid_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        idx_reg       <= idx_next;
        cmd_val_reg   <= cmd_val_next;
        cmd_t_reg     <= cmd_t_next;
        start_reg     <= start_next;
        best_val_reg  <= best_val_next;
        best_pos_reg  <= best_pos_next;
        out_kind_reg  <= out_kind_next;
        out_slot_reg  <= out_slot_next;
        out_time_reg  <= out_time_next;
        out_last_reg  <= out_last_next;
    end

    // slot store, one read and one write port, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
        rd_vld_reg  <= valid_reg[rd_addr];
    end

    a_slots_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_RPT_LOAD) && out_load && out_last_next |=> valid_reg == '0)
        else $error("slots not cleared after report");

    a_last_is_trough: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_last_reg |-> out_kind_reg)
        else $error("report ended on a peak slot");

endmodule
`default_nettype wire

// File: hdl/top_k_peak_trough_finder_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// top_k_peak_trough_finder_top
// Top-k local extrema finder over frames of signed Q7.8 samples.
// ----------------------------------------------------------------------------
// Samples enter one per transfer; a sample with k candidates (k up to two,
// plus one for the frame end) holds the input until they have gone into a
// four-entry command queue. The slot engine behind the queue handles each
// candidate by walking the slot store through its single read port one slot
// per cycle to find the weakest entry among the active slots of its kind;
// that scan sets the sustained rate when extrema are dense. On the last
// sample of a frame the engine streams peak_slots peak times and then
// trough_slots trough times, and clears its slots by valid bits in the same
// cycle the last result is loaded. Slot counts outside 1..SLOT_MAX are
// clipped.
// ----------------------------------------------------------------------------
module top_k_peak_trough_finder_top
    import tkpt_pkg::*;
#(
    parameter int SLOT_MAX = 8,
    parameter int FRAME_MAX = 128
)
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                cfg_write,
    input  wire                cfg_index,
    input  wire  [3:0]         cfg_data,
    input  wire                in_valid,
    output logic               in_stall,
    input  wire  signed [15:0] sample,
    input  wire                frame_end,
    output logic               out_valid,
    input  wire                out_stall,
    output logic               kind,
    output logic [2:0]         slot,
    output logic signed [7:0]  time_res,
    output logic               run_last
);

    localparam int  IW    = $clog2(FRAME_MAX);
    localparam int  CMD_W = 2 + 16 + IW;

    localparam logic CFG_PEAK_SLOTS   = 1'b0;
    localparam logic CFG_TROUGH_SLOTS = 1'b1;

    logic [3:0]       peak_slots_reg, peak_slots_next;
    logic [3:0]       trough_slots_reg, trough_slots_next;

    logic             push;
    logic [CMD_W-1:0] push_data;
    logic             fifo_full;
    logic             pop;
    logic [CMD_W-1:0] head_data;
    logic             head_valid;

    always_comb
    begin
        peak_slots_next   = peak_slots_reg;
        trough_slots_next = trough_slots_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_PEAK_SLOTS:   peak_slots_next   = cfg_data;
                CFG_TROUGH_SLOTS: trough_slots_next = cfg_data;
                default:          peak_slots_next   = peak_slots_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_slots_reg   <= 4'd1;
            trough_slots_reg <= 4'd1;
        end
        else
        begin
            peak_slots_reg   <= peak_slots_next;
            trough_slots_reg <= trough_slots_next;
        end
    end

    tkpt_front #(
        .FRAME_MAX (FRAME_MAX)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .sample    (sample),
        .frame_end (frame_end),
        .push      (push),
        .push_data (push_data),
        .fifo_full (fifo_full)
    );

    tkpt_fifo #(
        .W (CMD_W)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (fifo_full),
        .pop        (pop),
        .head_data  (head_data),
        .head_valid (head_valid)
    );

    tkpt_back #(
        .SLOT_MAX  (SLOT_MAX),
        .FRAME_MAX (FRAME_MAX)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .peak_slots   (peak_slots_reg),
        .trough_slots (trough_slots_reg),
        .head_valid   (head_valid),
        .head_data    (head_data),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .slot         (slot),
        .time_res     (time_res),
        .run_last     (run_last)
    );

endmodule
`default_nettype wire
